[rtl/dram_staggered_power_down_control_assert.svh]
// Assertion macros for the power-down controller.
`ifndef DRAM_STAGGERED_POWER_DOWN_CONTROL_ASSERT_SVH
`define DRAM_STAGGERED_POWER_DOWN_CONTROL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSPDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("power-down control check failed");

// next-cycle implication, sampled on clk, off during reset
`define DSPDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("power-down control check failed");

`endif

[rtl/dspdc_pkg.sv]
// Types and codes shared by the power-down controller modules.
package dspdc_pkg;

    typedef enum logic [2:0]
    {
        ACT_ENTRY  = 3'd0,
        ACT_EXIT   = 3'd1,
        ACT_INTR   = 3'd2,
        ACT_EVAL   = 3'd3,
        ACT_UPDATE = 3'd4
    } action_t;

    typedef enum logic [2:0]
    {
        MODE_IDLE   = 3'd0,
        MODE_ACT_PD = 3'd1,
        MODE_PRE_PD = 3'd2,
        MODE_SREF   = 3'd3,
        MODE_XREF   = 3'd4
    } mode_t;

    typedef enum logic [2:0]
    {
        NXT_NOP    = 3'd0,
        NXT_PDEA   = 3'd1,
        NXT_PDEP   = 3'd2,
        NXT_SREFEN = 3'd3,
        NXT_PDXA   = 3'd4,
        NXT_PDXP   = 3'd5,
        NXT_SREFEX = 3'd6,
        NXT_REFAB  = 3'd7
    } next_cmd_t;

    typedef enum logic [3:0]
    {
        ISS_OTHER  = 4'd0,
        ISS_PDEA   = 4'd1,
        ISS_PDEP   = 4'd2,
        ISS_SREFEN = 4'd3,
        ISS_PDXA   = 4'd4,
        ISS_PDXP   = 4'd5,
        ISS_SREFEX = 4'd6,
        ISS_REFAB  = 4'd7,
        ISS_REFPB  = 4'd8,
        ISS_REFP2B = 4'd9,
        ISS_REFSB  = 4'd10
    } issued_cmd_t;

    typedef struct packed
    {
        mode_t     mode;
        logic      quiet;
        logic      entry_pend;
        logic      exit_pend;
        logic      sref_pend;
        next_cmd_t chosen;
    } pd_state_t;

    localparam pd_state_t PD_STATE_RESET = '{
        mode:       MODE_IDLE,
        quiet:      1'b0,
        entry_pend: 1'b0,
        exit_pend:  1'b0,
        sref_pend:  1'b0,
        chosen:     NXT_NOP
    };

endpackage

[rtl/dspdc_step.sv]
// Next-state logic of the power-down controller for one event item.
module dspdc_step
(
    input  dspdc_pkg::pd_state_t   st,
    input  dspdc_pkg::action_t     action,
    input  logic                   any_bank_open,
    input  dspdc_pkg::issued_cmd_t issued_command,
    output dspdc_pkg::pd_state_t   st_next
);
    import dspdc_pkg::*;

    always_comb
    begin
        st_next = st;
        case (action)
            ACT_ENTRY:
            begin
                st_next.quiet = 1'b1;
                if (st.mode == MODE_IDLE)
                begin
                    st_next.entry_pend = 1'b1;
                end
            end
            ACT_EXIT:
            begin
                st_next.quiet      = 1'b0;
                st_next.sref_pend  = 1'b0;
                st_next.entry_pend = 1'b0;
                if (st.mode != MODE_IDLE)
                begin
                    st_next.exit_pend = 1'b1;
                end
            end
            ACT_INTR:
            begin
                st_next.entry_pend = 1'b0;
                if (st.mode != MODE_IDLE)
                begin
                    st_next.exit_pend = 1'b1;
                end
            end
            ACT_EVAL:
            begin
                st_next.chosen = NXT_NOP;
                if (st.exit_pend)
                begin
                    case (st.mode)
                        MODE_ACT_PD: st_next.chosen = NXT_PDXA;
                        MODE_PRE_PD: st_next.chosen = NXT_PDXP;
                        MODE_SREF:   st_next.chosen = NXT_SREFEX;
                        MODE_XREF:   st_next.chosen = NXT_REFAB;
                        default:     st_next.chosen = NXT_NOP;
                    endcase
                end
                else if (st.entry_pend)
                begin
                    st_next.chosen = any_bank_open ? NXT_PDEA : NXT_PDEP;
                end
                else if (st.sref_pend)
                begin
                    st_next.chosen = NXT_SREFEN;
                end
            end
            ACT_UPDATE:
            begin
                case (issued_command)
                    ISS_PDEA:
                    begin
                        st_next.mode       = MODE_ACT_PD;
                        st_next.entry_pend = 1'b0;
                    end
                    ISS_PDEP:
                    begin
                        st_next.mode       = MODE_PRE_PD;
                        st_next.entry_pend = 1'b0;
                    end
                    ISS_SREFEN:
                    begin
                        st_next.mode       = MODE_SREF;
                        st_next.entry_pend = 1'b0;
                        st_next.sref_pend  = 1'b0;
                    end
                    ISS_PDXA:
                    begin
                        st_next.mode      = MODE_IDLE;
                        st_next.exit_pend = 1'b0;
                    end
                    ISS_PDXP:
                    begin
                        st_next.mode      = MODE_IDLE;
                        st_next.exit_pend = 1'b0;
                        if (st.quiet)
                        begin
                            st_next.sref_pend = 1'b1;
                        end
                    end
                    ISS_SREFEX:
                    begin
                        st_next.mode = MODE_XREF;
                    end
                    ISS_REFAB:
                    begin
                        if (st.mode == MODE_XREF)
                        begin
                            st_next.mode      = MODE_IDLE;
                            st_next.exit_pend = 1'b0;
                        end
                        else if (st.quiet)
                        begin
                            st_next.entry_pend = 1'b1;
                        end
                    end
                    ISS_REFPB, ISS_REFP2B, ISS_REFSB:
                    begin
                        if (st.quiet)
                        begin
                            st_next.entry_pend = 1'b1;
                        end
                    end
                    default:
                    begin
                        st_next = st;
                    end
                endcase
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

[rtl/dram_staggered_power_down_control.sv]
// Top level of the per-rank DRAM power-down and self-refresh controller.
// An accepted item is held in the input register; its result is registered in the result register.
// Throughput: one item per cycle while the output is not stalled; the state updates once per item.
// Output stalls are absorbed by the result register; the input register refills as it drains.
// Reset (rst_n low, asynchronous): idle mode, all pending flags clear, next command NOP.
`include "dram_staggered_power_down_control_assert.svh"

module dram_staggered_power_down_control
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] any_bank_open, [4:1] issued_command, [7:5] zero
    input  logic [2:0] s_axis_tuser,   // [2:0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] next_command, [5:3] power_mode, [7:6] zero
);
    import dspdc_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  in_action_reg;
    logic        in_bank_reg;
    logic [3:0]  in_cmd_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_data_reg;
    pd_state_t   st_reg;
    pd_state_t   st_next;
    logic        advance;
    logic        in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    dspdc_step u_step
    (
        .st             (st_reg),
        .action         (action_t'(in_action_reg)),
        .any_bank_open  (in_bank_reg),
        .issued_command (issued_cmd_t'(in_cmd_reg)),
        .st_next        (st_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= PD_STATE_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= s_axis_tuser;
            in_bank_reg   <= s_axis_tdata[0];
            in_cmd_reg    <= s_axis_tdata[4:1];
        end
        if (advance)
        begin
            out_data_reg <= {2'b00, st_next.mode, st_next.chosen};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `DSPDC_ASSERT_IMPL(a_idle_no_exit, st_reg.mode == MODE_IDLE, !st_reg.exit_pend)
    `DSPDC_ASSERT_IMPL(a_sref_entry_clears,
        st_reg.mode == MODE_SREF && $past(st_reg.mode) != MODE_SREF && $past(rst_n),
        !st_reg.entry_pend && !st_reg.sref_pend)
    `DSPDC_ASSERT_NEXT(a_hold_state, !advance, $stable(st_reg))
    `DSPDC_ASSERT_NEXT(a_result_follows, advance, out_valid_reg)
    `DSPDC_ASSERT_IMPL(a_out_matches_state, out_valid_reg,
        (out_data_reg == {2'b00, st_reg.mode, st_reg.chosen}))

endmodule

[bench/dram_staggered_power_down_control_test.sv]
// Stream testbench for the DRAM power-down controller: directed walk, random events, scoreboard.
module dram_staggered_power_down_control_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dspdc_pkg::*;

    localparam int          RANDOM_ITEMS   = 500;
    localparam int          TAIL_ITEMS     = 60;
    localparam int          LONG_HOLD      = 60;
    localparam int          HOLD_AT_ITEM   = 120;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          CYCLE_LIMIT    = 100000;
    localparam logic [2:0]  ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI  = 3'd7;
    localparam logic [3:0]  ISS_UNUSED_MAX = 4'd15;

    typedef struct packed
    {
        next_cmd_t nxt;
        mode_t     mode;
    } pd_result_t;

    typedef struct packed
    {
        logic [2:0] act;
        logic       bank;
        logic [3:0] cmd;
        logic       typed;
        next_cmd_t  nxt;
        mode_t      mode;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ACT_EVAL,      1'b0, ISS_OTHER,      1'b1, NXT_NOP, MODE_IDLE},
        '{ACT_UNUSED_LO, 1'b1, ISS_OTHER,      1'b1, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_UNUSED_MAX, 1'b1, NXT_NOP, MODE_IDLE},
        '{ACT_EXIT,      1'b1, ISS_REFSB,      1'b1, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b1, ISS_OTHER,      1'b1, NXT_NOP, MODE_IDLE},
        '{ACT_ENTRY,     1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b1, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_PDEA,       1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EXIT,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_PDXA,       1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_ENTRY,     1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b1, ISS_PDEP,       1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_INTR,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b1, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_PDXP,       1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_SREFEN,     1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_REFAB,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EXIT,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b0, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_SREFEX,     1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_EVAL,      1'b1, ISS_OTHER,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UPDATE,    1'b0, ISS_REFAB,      1'b0, NXT_NOP, MODE_IDLE},
        '{ACT_UNUSED_HI, 1'b1, ISS_UNUSED_MAX, 1'b0, NXT_NOP, MODE_IDLE}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [2:0] s_axis_tuser = ACT_ENTRY;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    pd_state_t  pm = PD_STATE_RESET;
    pd_result_t expected_results [$];
    int         items_sent = 0;
    int         results_seen = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         rx_hold = 0;
    bit         long_hold_done = 1'b0;
    bit         tail_phase = 1'b0;

    dram_staggered_power_down_control u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // power-state predictor: applies one event, returns chosen command and mode
    function automatic pd_result_t advance_power_fsm(input logic [2:0] act, input logic bank,
                                                     input logic [3:0] cmd);
        pd_result_t r;
        case (act)
            ACT_ENTRY:
            begin
                pm.quiet = 1'b1;
                if (pm.mode == MODE_IDLE)
                    pm.entry_pend = 1'b1;
            end
            ACT_EXIT:
            begin
                pm.quiet = 1'b0;
                pm.sref_pend = 1'b0;
                pm.entry_pend = 1'b0;
                if (pm.mode != MODE_IDLE)
                    pm.exit_pend = 1'b1;
            end
            ACT_INTR:
            begin
                pm.entry_pend = 1'b0;
                if (pm.mode != MODE_IDLE)
                    pm.exit_pend = 1'b1;
            end
            ACT_EVAL:
            begin
                pm.chosen = NXT_NOP;
                if (pm.exit_pend)
                begin
                    case (pm.mode)
                        MODE_ACT_PD: pm.chosen = NXT_PDXA;
                        MODE_PRE_PD: pm.chosen = NXT_PDXP;
                        MODE_SREF:   pm.chosen = NXT_SREFEX;
                        MODE_XREF:   pm.chosen = NXT_REFAB;
                        default:     pm.chosen = NXT_NOP;
                    endcase
                end
                else if (pm.entry_pend)
                    pm.chosen = bank ? NXT_PDEA : NXT_PDEP;
                else if (pm.sref_pend)
                    pm.chosen = NXT_SREFEN;
            end
            ACT_UPDATE:
            begin
                case (cmd)
                    ISS_PDEA:
                    begin
                        pm.mode = MODE_ACT_PD;
                        pm.entry_pend = 1'b0;
                    end
                    ISS_PDEP:
                    begin
                        pm.mode = MODE_PRE_PD;
                        pm.entry_pend = 1'b0;
                    end
                    ISS_SREFEN:
                    begin
                        pm.mode = MODE_SREF;
                        pm.entry_pend = 1'b0;
                        pm.sref_pend = 1'b0;
                    end
                    ISS_PDXA:
                    begin
                        pm.mode = MODE_IDLE;
                        pm.exit_pend = 1'b0;
                    end
                    ISS_PDXP:
                    begin
                        pm.mode = MODE_IDLE;
                        pm.exit_pend = 1'b0;
                        if (pm.quiet)
                            pm.sref_pend = 1'b1;
                    end
                    ISS_SREFEX:
                        pm.mode = MODE_XREF;
                    ISS_REFAB:
                    begin
                        if (pm.mode == MODE_XREF)
                        begin
                            pm.mode = MODE_IDLE;
                            pm.exit_pend = 1'b0;
                        end
                        else if (pm.quiet)
                            pm.entry_pend = 1'b1;
                    end
                    ISS_REFPB, ISS_REFP2B, ISS_REFSB:
                    begin
                        if (pm.quiet)
                            pm.entry_pend = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.nxt = pm.chosen;
        r.mode = pm.mode;
        return r;
    endfunction

    task automatic send_event(input logic [2:0] act, input logic bank, input logic [3:0] cmd,
                              input logic typed, input next_cmd_t t_nxt, input mode_t t_mode);
        pd_result_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'b000, cmd, bank};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = advance_power_fsm(act, bank, cmd);
        if (typed)
        begin
            r.nxt = t_nxt;
            r.mode = t_mode;
        end
        expected_results.push_back(r);
        items_sent <= items_sent + 1;
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // receiver: random backpressure, one long hold-off, scoreboard compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected item: next_command %0d power_mode %0d",
                           m_axis_tdata[2:0], m_axis_tdata[5:3]);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    pd_result_t want;
                    want = expected_results.pop_front();
                    if (m_axis_tdata[2:0] !== want.nxt)
                    begin
                        $error("next_command: expected %0d, actual %0d",
                               want.nxt, m_axis_tdata[2:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[5:3] !== want.mode)
                    begin
                        $error("power_mode: expected %0d, actual %0d",
                               want.mode, m_axis_tdata[5:3]);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (rx_hold != 0)
            begin
                rx_hold <= rx_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!tail_phase && !long_hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                long_hold_done <= 1'b1;
                rx_hold <= LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!tail_phase && $urandom_range(0, 6) == 0)
            begin
                rx_hold <= $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [2:0] act;
        logic       bank;
        logic [3:0] cmd;
        int         pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 8));
            send_event(dir_rows[i].act, dir_rows[i].bank, dir_rows[i].cmd,
                       dir_rows[i].typed, dir_rows[i].nxt, dir_rows[i].mode);
        end

        // mostly controller-like traffic: issue what evaluate chose; the rest is noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase <= 1'b1;
            if (i < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            bank = 1'($urandom_range(0, 1));
            cmd = 4'($urandom_range(0, 15));
            if (pick < 14)
                act = ACT_ENTRY;
            else if (pick < 22)
                act = ACT_EXIT;
            else if (pick < 28)
                act = ACT_INTR;
            else if (pick < 55)
                act = ACT_EVAL;
            else if (pick < 80)
            begin
                act = ACT_UPDATE;
                cmd = (pm.chosen == NXT_NOP) ? issued_cmd_t'($urandom_range(ISS_REFAB, ISS_REFSB))
                                             : {1'b0, pm.chosen};
            end
            else if (pick < 88)
            begin
                act = ACT_UPDATE;
                cmd = 4'($urandom_range(ISS_REFAB, ISS_REFSB));
            end
            else
                act = 3'($urandom_range(0, 7));
            send_event(act, bank, cmd, 1'b0, NXT_NOP, MODE_IDLE);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items: directed power-state walk, then random events and updates",
                 items_sent);
        $display("Compared %0d results under random backpressure and one long receiver stall",
                 results_seen);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
